// File: sv/generational_handle_table_defines.svh
// assertion macros for the generational handle table checker
// needs a clk and rst_n in scope where the macros are used
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// same-cycle implication
`define GHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ght_pkg.sv
// shared types and constants for the generational handle table
// used by the top level and its checker, no dependencies
`default_nettype none

package ght_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int GEN_W      = 32;
  localparam int OBJ_W      = 64;
  localparam int OKIND_W    = 16;
  localparam int KIND_W     = 17;

  localparam logic [KIND_W-1:0] KIND_NONE = {KIND_W{1'b1}};

  typedef enum logic [1:0] {
    OP_TRACK   = 2'd0,
    OP_UNTRACK = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_FIND    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: sv/generational_handle_table.sv
// generational handle table: slot map with free stack, track/untrack/resolve/find
// single-port object, kind, generation and free-stack memories under one sequencer
// depends on ght_pkg
//
//   channel   ports                         transfer
//   input     start, busy, in_*             start high and busy low at clk edge
//   result    out_valid, out_*              out_valid high, one cycle, no stall
//
// refused ops and track from the high-water mark are decided in idle; untrack and resolve
// are decided in the check state; track from the free stack passes the pop and generation states;
// find scans slots up to high_water (one slot compared per cycle through the table port)
// busy stays high while an op runs outside the idle state; results cannot be held off
// reset needs no clearing pass: slots above high_water never affect a result
`default_nettype none

module generational_handle_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [1:0]                          in_kind,
  input  logic [ght_pkg::SLOT_W-1:0]          in_handle_slot,
  input  logic [ght_pkg::GEN_W-1:0]           in_handle_generation,
  input  logic [ght_pkg::OBJ_W-1:0]           in_object_ref,
  input  logic [ght_pkg::OKIND_W-1:0]         in_object_kind,
  output logic                                busy,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [ght_pkg::SLOT_W-1:0]          out_slot,
  output logic [ght_pkg::GEN_W-1:0]           out_generation,
  output logic [ght_pkg::OBJ_W-1:0]           out_object,
  output logic signed [ght_pkg::KIND_W-1:0]   out_kind,
  output logic                                out_released
);
  import ght_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_POP  = 5'b00010,
    S_TGEN = 5'b00100,
    S_CHK  = 5'b01000,
    S_SCAN = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   hw_r, hw_nxt;
  logic [CNT_W-1:0]    fc_r, fc_nxt;
  op_t                 op_r, op_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [GEN_W-1:0]    hgen_r, hgen_nxt;
  logic [OBJ_W-1:0]    obj_r, obj_nxt;
  logic [OKIND_W-1:0]  okind_r, okind_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]   cmp_slot_r, cmp_slot_nxt;

  logic                ov_r;
  status_t             status_r;
  logic [SLOT_W-1:0]   oslot_r;
  logic [GEN_W-1:0]    ogen_r;
  logic [OBJ_W-1:0]    oobj_r;
  logic [KIND_W-1:0]   okind_out_r;
  logic                rel_r;

  logic [OBJ_W-1:0]    obj_mem_r  [SLOT_COUNT];
  logic [GEN_W-1:0]    gen_mem_r  [SLOT_COUNT];
  logic [KIND_W-1:0]   kind_mem_r [SLOT_COUNT];
  logic [SLOT_W-1:0]   stk_mem_r  [SLOT_COUNT];
  logic [OBJ_W-1:0]    obj_rd_r;
  logic [GEN_W-1:0]    gen_rd_r;
  logic [KIND_W-1:0]   kind_rd_r;
  logic [SLOT_W-1:0]   stk_rd_r;

  logic                tbl_we;
  logic [SLOT_W-1:0]   tbl_addr;
  logic [OBJ_W-1:0]    obj_wd;
  logic [GEN_W-1:0]    gen_wd;
  logic [KIND_W-1:0]   kind_wd;
  logic                stk_we;
  logic [SLOT_W-1:0]   stk_addr;
  logic [SLOT_W-1:0]   stk_wd;

  logic                done;
  status_t             res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [GEN_W-1:0]    res_gen;
  logic [OBJ_W-1:0]    res_obj;
  logic [KIND_W-1:0]   res_kind;
  logic                res_rel;

  logic [CNT_W-1:0]    fc_m1;
  logic [SLOT_W-1:0]   hw_inc;
  logic                hw_full;
  logic [GEN_W-1:0]    gen_inc;
  logic [GEN_W-1:0]    gen_bump;
  logic                scan_issue;

  assign fc_m1      = fc_r - CNT_W'(1);
  assign hw_inc     = hw_r + SLOT_W'(1);
  assign hw_full    = (hw_r == SLOT_W'(SLOT_COUNT - 1));
  assign gen_inc    = gen_rd_r + GEN_W'(1);
  assign gen_bump   = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  assign scan_issue = (scan_r <= {1'b0, hw_r});

  always_comb begin
    state_nxt    = state_r;
    hw_nxt       = hw_r;
    fc_nxt       = fc_r;
    op_nxt       = op_r;
    slot_nxt     = slot_r;
    hgen_nxt     = hgen_r;
    obj_nxt      = obj_r;
    okind_nxt    = okind_r;
    scan_nxt     = scan_r;
    cmp_vld_nxt  = 1'b0;
    cmp_slot_nxt = cmp_slot_r;

    tbl_we   = 1'b0;
    tbl_addr = in_handle_slot;
    obj_wd   = obj_r;
    gen_wd   = GEN_W'(1);
    kind_wd  = {1'b0, okind_r};
    stk_we   = 1'b0;
    stk_addr = fc_m1[SLOT_W-1:0];
    stk_wd   = slot_r;

    done       = 1'b0;
    res_status = ST_OK;
    res_slot   = '0;
    res_gen    = '0;
    res_obj    = '0;
    res_kind   = '0;
    res_rel    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = op_t'(in_kind);
          slot_nxt  = in_handle_slot;
          hgen_nxt  = in_handle_generation;
          obj_nxt   = in_object_ref;
          okind_nxt = in_object_kind;
          case (op_t'(in_kind))
            OP_TRACK: begin
              if (in_object_ref == '0) begin
                done       = 1'b1;
                res_status = ST_STALE;
              end else if (fc_r != '0) begin
                state_nxt = S_POP;
              end else if (hw_full) begin
                done       = 1'b1;
                res_status = ST_FULL;
              end else begin
                hw_nxt   = hw_inc;
                tbl_we   = 1'b1;
                tbl_addr = hw_inc;
                obj_wd   = in_object_ref;
                kind_wd  = {1'b0, in_object_kind};
                gen_wd   = GEN_W'(1);
                done     = 1'b1;
                res_slot = hw_inc;
                res_gen  = GEN_W'(1);
              end
            end
            OP_UNTRACK, OP_RESOLVE: begin
              if (in_handle_slot != '0 && in_handle_slot <= hw_r) begin
                state_nxt = S_CHK;
              end else begin
                done       = 1'b1;
                res_status = ST_STALE;
                if (op_t'(in_kind) == OP_RESOLVE) begin
                  res_kind = KIND_NONE;
                end
              end
            end
            OP_FIND: begin
              if (in_object_ref == '0) begin
                done       = 1'b1;
                res_status = ST_STALE;
              end else begin
                scan_nxt  = CNT_W'(1);
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        tbl_addr  = stk_rd_r;
        slot_nxt  = stk_rd_r;
        fc_nxt    = fc_m1;
        state_nxt = S_TGEN;
      end
      S_TGEN: begin
        tbl_addr  = slot_r;
        tbl_we    = 1'b1;
        gen_wd    = (gen_rd_r == '0) ? GEN_W'(1) : gen_rd_r;
        done      = 1'b1;
        res_slot  = slot_r;
        res_gen   = gen_wd;
        state_nxt = S_IDLE;
      end
      S_CHK: begin
        tbl_addr  = slot_r;
        done      = 1'b1;
        state_nxt = S_IDLE;
        if (gen_rd_r != hgen_r || obj_rd_r == '0) begin
          res_status = ST_STALE;
          if (op_r == OP_RESOLVE) begin
            res_kind = KIND_NONE;
          end
        end else if (op_r == OP_RESOLVE) begin
          res_obj  = obj_rd_r;
          res_kind = kind_rd_r;
        end else begin
          tbl_we  = 1'b1;
          obj_wd  = '0;
          kind_wd = KIND_NONE;
          gen_wd  = gen_bump;
          res_rel = 1'b1;
          if (fc_r < CNT_W'(SLOT_COUNT)) begin
            stk_we   = 1'b1;
            stk_addr = fc_r[SLOT_W-1:0];
            stk_wd   = slot_r;
            fc_nxt   = fc_r + CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        tbl_addr     = scan_r[SLOT_W-1:0];
        scan_nxt     = scan_r + CNT_W'(1);
        cmp_vld_nxt  = scan_issue;
        cmp_slot_nxt = scan_r[SLOT_W-1:0];
        if (cmp_vld_r && obj_rd_r == obj_r) begin
          done        = 1'b1;
          res_slot    = cmp_slot_r;
          res_gen     = gen_rd_r;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end else if (!cmp_vld_r && !scan_issue) begin
          done       = 1'b1;
          res_status = ST_STALE;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // table memories, one shared address
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      obj_mem_r[tbl_addr]  <= obj_wd;
      gen_mem_r[tbl_addr]  <= gen_wd;
      kind_mem_r[tbl_addr] <= kind_wd;
    end
    obj_rd_r  <= obj_mem_r[tbl_addr];
    gen_rd_r  <= gen_mem_r[tbl_addr];
    kind_rd_r <= kind_mem_r[tbl_addr];
  end

  // free stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem_r[stk_addr] <= stk_wd;
    end
    stk_rd_r <= stk_mem_r[stk_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      hw_r      <= '0;
      fc_r      <= '0;
      cmp_vld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      hw_r      <= hw_nxt;
      fc_r      <= fc_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      ov_r      <= done;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    slot_r     <= slot_nxt;
    hgen_r     <= hgen_nxt;
    obj_r      <= obj_nxt;
    okind_r    <= okind_nxt;
    scan_r     <= scan_nxt;
    cmp_slot_r <= cmp_slot_nxt;
    if (done) begin
      status_r    <= res_status;
      oslot_r     <= res_slot;
      ogen_r      <= res_gen;
      oobj_r      <= res_obj;
      okind_out_r <= res_kind;
      rel_r       <= res_rel;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = ov_r;
  assign out_status     = status_r;
  assign out_slot       = oslot_r;
  assign out_generation = ogen_r;
  assign out_object     = oobj_r;
  assign out_kind       = $signed(okind_out_r);
  assign out_released   = rel_r;

endmodule

`default_nettype wire

// File: sv/ght_checker.sv
// port-level checker for the generational handle table, bound to the top level
// depends on ght_pkg and generational_handle_table_defines.svh
`default_nettype none
`include "generational_handle_table_defines.svh"

module ght_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire logic                                out_valid,
  input  wire logic [1:0]                          out_status,
  input  wire logic [ght_pkg::SLOT_W-1:0]          out_slot,
  input  wire logic [ght_pkg::GEN_W-1:0]           out_generation,
  input  wire logic [ght_pkg::OBJ_W-1:0]           out_object,
  input  wire logic signed [ght_pkg::KIND_W-1:0]   out_kind,
  input  wire logic                                out_released
);
  import ght_pkg::*;

  // an accepted transfer either keeps the block busy or answers at once
  `GHT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "accepted item lost")

  `GHT_ASSERT_NOW(a_status_code, out_valid, out_status == ST_OK || out_status == ST_FULL || out_status == ST_STALE, "bad status code")

  `GHT_ASSERT_NOW(a_release_clean, out_valid && out_released, out_status == ST_OK && out_slot == '0 && out_generation == '0 && out_object == '0, "release result carries payload")

  `GHT_ASSERT_NOW(a_handle_gen, out_valid && out_slot != '0, out_status == ST_OK && out_generation != '0, "handle with zero generation")

  `GHT_ASSERT_NOW(a_bad_resolve, out_valid && out_kind == KIND_NONE, out_status == ST_STALE && out_object == '0, "failed resolve with ok status")

endmodule

bind generational_handle_table ght_checker u_ght_checker (.*);

`default_nettype wire

// File: bench/tb_generational_handle_table.sv
`timescale 1ns / 1ps
// self-checking bench for generational_handle_table: directed ops, then random table traffic
// a queue-fed driver, a shadow slot table predicting every reply, and a reply checker
// depends on ght_pkg and generational_handle_table
module tb_generational_handle_table;
  import ght_pkg::*;

  typedef enum int {PK_RAW, PK_LIVE, PK_OLD_GEN, PK_FREED, PK_SAME_OBJ} pick_t;

  typedef struct {
    op_t                  op;
    pick_t                pick;
    logic [SLOT_W-1:0]    slot;
    logic [GEN_W-1:0]     gen;
    logic [OBJ_W-1:0]     obj;
    logic [OKIND_W-1:0]   okind;
    int                   idle_pct;
    bit                   drain;
  } work_item_t;

  typedef struct {
    logic [1:0]                status;
    logic [SLOT_W-1:0]         slot;
    logic [GEN_W-1:0]          gen;
    logic [OBJ_W-1:0]          obj;
    logic signed [KIND_W-1:0]  kind;
    logic                      released;
  } reply_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic [1:0]                 in_kind = OP_TRACK;
  logic [SLOT_W-1:0]          in_handle_slot = '0;
  logic [GEN_W-1:0]           in_handle_generation = '0;
  logic [OBJ_W-1:0]           in_object_ref = '0;
  logic [OKIND_W-1:0]         in_object_kind = '0;
  logic                       busy;
  logic                       out_valid;
  logic [1:0]                 out_status;
  logic [SLOT_W-1:0]          out_slot;
  logic [GEN_W-1:0]           out_generation;
  logic [OBJ_W-1:0]           out_object;
  logic signed [KIND_W-1:0]   out_kind;
  logic                       out_released;

  generational_handle_table uut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_kind(in_kind),
    .in_handle_slot(in_handle_slot), .in_handle_generation(in_handle_generation),
    .in_object_ref(in_object_ref), .in_object_kind(in_object_kind),
    .busy(busy), .out_valid(out_valid), .out_status(out_status), .out_slot(out_slot),
    .out_generation(out_generation), .out_object(out_object), .out_kind(out_kind),
    .out_released(out_released)
  );

  // shadow slot table
  logic [OBJ_W-1:0]   obj_mem   [SLOT_COUNT];
  logic [GEN_W-1:0]   gen_mem   [SLOT_COUNT];
  logic [KIND_W-1:0]  kind_mem  [SLOT_COUNT];
  int                 free_stack[SLOT_COUNT];
  int                 free_cnt = 0;
  int                 high_water = 0;
  int                 live_slots[$];

  work_item_t  work_q[$];
  reply_t      replies_due[$];
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_items = 0;
  int          errors = 0;

  initial begin
    foreach (gen_mem[i]) gen_mem[i] = '0;
  end

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit slot_live(int s, logic [GEN_W-1:0] g);
    if (s == 0 || s > high_water) return 0;
    return gen_mem[s] == g && obj_mem[s] != '0;
  endfunction

  function automatic reply_t table_step(op_t op, logic [SLOT_W-1:0] hs, logic [GEN_W-1:0] hg,
                                        logic [OBJ_W-1:0] obj, logic [OKIND_W-1:0] okind);
    reply_t r;
    int s;
    logic [GEN_W-1:0] g;
    r = '{status: ST_OK, slot: '0, gen: '0, obj: '0, kind: '0, released: 1'b0};
    case (op)
      OP_TRACK: begin
        s = 0;
        if (obj == '0) begin
          r.status = ST_STALE;
        end else begin
          if (free_cnt > 0) begin
            free_cnt--;
            s = free_stack[free_cnt];
          end else if (high_water + 1 < SLOT_COUNT) begin
            high_water++;
            s = high_water;
          end
          if (s == 0) begin
            r.status = ST_FULL;
          end else begin
            obj_mem[s] = obj;
            kind_mem[s] = {1'b0, okind};
            if (gen_mem[s] == '0) gen_mem[s] = GEN_W'(1);
            live_slots.push_back(s);
            r.slot = SLOT_W'(s);
            r.gen = gen_mem[s];
          end
        end
      end
      OP_UNTRACK: begin
        if (!slot_live(int'(hs), hg)) begin
          r.status = ST_STALE;
        end else begin
          g = gen_mem[hs] + GEN_W'(1);
          obj_mem[hs] = '0;
          kind_mem[hs] = KIND_NONE;
          gen_mem[hs] = (g == '0) ? GEN_W'(1) : g;
          if (free_cnt < SLOT_COUNT) begin
            free_stack[free_cnt] = int'(hs);
            free_cnt++;
          end
          foreach (live_slots[i]) begin
            if (live_slots[i] == int'(hs)) begin
              live_slots.delete(i);
              break;
            end
          end
          r.released = 1'b1;
        end
      end
      OP_RESOLVE: begin
        if (!slot_live(int'(hs), hg)) begin
          r.status = ST_STALE;
          r.kind = KIND_NONE;
        end else begin
          r.obj = obj_mem[hs];
          r.kind = kind_mem[hs];
        end
      end
      default: begin
        r.status = ST_STALE;
        if (obj != '0) begin
          for (s = 1; s <= high_water; s++) begin
            if (obj_mem[s] == obj) begin
              r.status = ST_OK;
              r.slot = SLOT_W'(s);
              r.gen = gen_mem[s];
              break;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic queue_op(op_t op, int slot, logic [GEN_W-1:0] gen, logic [OBJ_W-1:0] obj,
                          logic [OKIND_W-1:0] okind);
    work_item_t w;
    w = '{op: op, pick: PK_RAW, slot: SLOT_W'(slot), gen: gen, obj: obj, okind: okind,
          idle_pct: 0, drain: 1'b0};
    work_q.push_back(w);
  endtask

  function automatic work_item_t random_item(int idle_pct, bit filling);
    work_item_t w;
    int r;
    int o;
    w.slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    w.gen = $urandom_range(0, 1) ? GEN_W'($urandom) : GEN_W'($urandom_range(0, 3));
    w.obj = {$urandom, $urandom};
    w.okind = OKIND_W'($urandom_range(0, 65535));
    w.idle_pct = idle_pct;
    w.drain = 1'b0;
    w.pick = PK_RAW;
    o = $urandom_range(0, 99);
    if (filling) begin
      w.op = (o < 97) ? OP_TRACK : (o < 98) ? OP_UNTRACK : (o < 99) ? OP_RESOLVE : OP_FIND;
    end else begin
      w.op = (o < 30) ? OP_TRACK : (o < 60) ? OP_UNTRACK : (o < 85) ? OP_RESOLVE : OP_FIND;
    end
    r = $urandom_range(0, 99);
    case (w.op)
      OP_TRACK: begin
        if (r < 8 && !filling) w.obj = '0;
        else if (r < 23) w.pick = PK_SAME_OBJ;
      end
      OP_FIND: begin
        if (r < 50 || filling) w.pick = PK_SAME_OBJ;
        else if (r < 60) w.obj = '0;
      end
      default: begin
        if (r < 65) w.pick = PK_LIVE;
        else if (r < 75) w.pick = PK_OLD_GEN;
        else if (r < 85) w.pick = PK_FREED;
      end
    endcase
    return w;
  endfunction

  task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
  endtask

  // driver: predicts each accepted transfer, then loads the next pending item
  always @(posedge clk) begin
    reply_t r;
    work_item_t w;
    bit took;
    int s;
    took = 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        r = table_step(op_t'(in_kind), in_handle_slot, in_handle_generation,
                       in_object_ref, in_object_kind);
        replies_due.push_back(r);
        n_accepted <= n_accepted + 1;
        took = 1;
      end
      if (!start || took) begin
        if (work_q.size() == 0) begin
          start <= 1'b0;
        end else if (work_q[0].drain && (took || n_accepted != n_results)) begin
          start <= 1'b0;
        end else if ($urandom_range(0, 99) < work_q[0].idle_pct) begin
          start <= 1'b0;
        end else begin
          w = work_q.pop_front();
          case (w.pick)
            PK_LIVE, PK_OLD_GEN: begin
              if (live_slots.size() > 0) begin
                s = live_slots[$urandom_range(0, live_slots.size() - 1)];
                w.slot = SLOT_W'(s);
                w.gen = gen_mem[s];
                if (w.pick == PK_OLD_GEN)
                  w.gen = $urandom_range(0, 1) ? w.gen - GEN_W'(1) : w.gen + GEN_W'(1);
              end
            end
            PK_FREED: begin
              if (free_cnt > 0) begin
                s = free_stack[$urandom_range(0, free_cnt - 1)];
                w.slot = SLOT_W'(s);
                w.gen = gen_mem[s] - GEN_W'($urandom_range(0, 1));
              end
            end
            PK_SAME_OBJ: begin
              if (live_slots.size() > 0)
                w.obj = obj_mem[live_slots[$urandom_range(0, live_slots.size() - 1)]];
            end
            default: ;
          endcase
          in_kind <= w.op;
          in_handle_slot <= w.slot;
          in_handle_generation <= w.gen;
          in_object_ref <= w.obj;
          in_object_kind <= w.okind;
          start <= 1'b1;
        end
      end
    end
  end

  // monitor: every strobed reply is checked against the oldest prediction
  always @(posedge clk) begin
    reply_t r;
    if (rst_n && out_valid) begin
      n_results <= n_results + 1;
      if (replies_due.size() == 0) begin
        note_mismatch("unexpected transfer, status", 64'(out_status), 64'(0));
      end else begin
        r = replies_due.pop_front();
        if (out_status !== r.status)
          note_mismatch("status", 64'(out_status), 64'(r.status));
        if (out_slot !== r.slot)
          note_mismatch("slot", 64'(out_slot), 64'(r.slot));
        if (out_generation !== r.gen)
          note_mismatch("generation", 64'(out_generation), 64'(r.gen));
        if (out_object !== r.obj)
          note_mismatch("object", out_object, r.obj);
        if (out_kind !== r.kind)
          note_mismatch("kind", 64'(out_kind), 64'(r.kind));
        if (out_released !== r.released)
          note_mismatch("released", 64'(out_released), 64'(r.released));
      end
    end
  end

  initial begin
    int idle_by_phase[3];
    work_item_t w;
    idle_by_phase = '{0, 46, 21};

    // empty table, refused operands
    queue_op(OP_RESOLVE, 0, 0, 0, 0);
    queue_op(OP_UNTRACK, 5, 1, 0, 0);
    queue_op(OP_FIND, 0, 0, 0, 0);
    queue_op(OP_TRACK, 0, 0, 0, 16'h1234);
    // allocation from the high-water mark, field extremes
    queue_op(OP_TRACK, 0, 0, '1, 16'hffff);
    queue_op(OP_TRACK, SLOT_COUNT - 1, '1, 64'd1, 16'h0000);
    queue_op(OP_TRACK, 0, 0, 64'h8000_0000_0000_0000, 16'h8000);
    queue_op(OP_RESOLVE, 1, 1, 0, 0);
    queue_op(OP_RESOLVE, 3, 1, 0, 0);
    queue_op(OP_FIND, 0, 0, '1, 0);
    queue_op(OP_FIND, 0, 0, 64'd12345, 0);
    // bad handles: wrong generation, slot zero, not live after a release
    queue_op(OP_RESOLVE, 2, 2, 0, 0);
    queue_op(OP_RESOLVE, 0, 1, 0, 0);
    queue_op(OP_UNTRACK, 2, 1, 0, 0);
    queue_op(OP_UNTRACK, 2, 1, 0, 0);
    queue_op(OP_UNTRACK, 2, 2, 0, 0);
    queue_op(OP_RESOLVE, 2, 2, 0, 0);
    // reuse from the free stack and duplicate objects
    queue_op(OP_TRACK, 0, 0, 64'd1, 16'd7);
    queue_op(OP_TRACK, 0, 0, 64'd1, 16'd9);
    queue_op(OP_FIND, 0, 0, 64'd1, 0);
    queue_op(OP_RESOLVE, SLOT_COUNT - 1, '1, 0, 0);
    queue_op(OP_UNTRACK, 1, 1, 0, 0);
    queue_op(OP_UNTRACK, 3, 1, 0, 0);
    queue_op(OP_TRACK, 0, 0, 64'h5555_aaaa_5555_aaaa, 16'h00ff);
    queue_op(OP_TRACK, 0, 0, 64'haaaa_5555_aaaa_5555, 16'hff00);

    // mixed traffic with a small table
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 100; i++) begin
        w = random_item(idle_by_phase[p], 1'b0);
        w.drain = (i == 0);
        work_q.push_back(w);
      end
    end
    // fill the table past capacity, then keep churning at full
    for (int i = 0; i < 1120; i++) begin
      w = random_item(idle_by_phase[(i / 200) % 3], 1'b1);
      w.drain = (i % 400 == 0);
      work_q.push_back(w);
    end
    n_items = work_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_results >= n_items);
    repeat (20) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0 && n_results == n_items) begin
      $display("generational_handle_table test passed");
    end else begin
      $display("generational_handle_table test failed");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("generational_handle_table test failed");
    $finish;
  end

endmodule
